FILE: src/cfarb_pkg.sv
// ----------------------------------------------------------------------------
// cfarb_pkg
// Shared constants for the ring background averaging unit.
// ----------------------------------------------------------------------------
`default_nettype none
package cfarb_pkg;

  localparam int CfgIndexWidth = 2;
  localparam int CfgDataWidth  = 11;

  localparam logic [CfgIndexWidth-1:0] CFG_IMAGE_WIDTH     = 2'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_BACKGROUND_HALF = 2'd1;
  localparam logic [CfgIndexWidth-1:0] CFG_GUARD_HALF      = 2'd2;

  localparam logic [10:0] IMAGE_WIDTH_RESET     = 11'd640;
  localparam logic [2:0]  BACKGROUND_HALF_RESET = 3'd5;
  localparam logic [2:0]  GUARD_HALF_RESET      = 3'd2;

  localparam int MAX_HALF = 7;

  localparam int PixelWidth = 8;
  localparam int WordWidth  = 9;   // mask bit over pixel
  localparam int SumWidth   = 16;
  localparam int CountWidth = 8;
  localparam int AvgWidth   = 16;

endpackage
`default_nettype wire

FILE: src/cfarb_ifs.sv
// ----------------------------------------------------------------------------
// cfarb stream interfaces
// Valid/ready channels for pixel words and result words.
// ----------------------------------------------------------------------------
`default_nettype none
interface cfarb_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;
  logic       mask_bit;
  logic       frame_start;
  logic       padding;

  modport source (output valid, pixel, mask_bit, frame_start, padding, input ready);
  modport sink   (input valid, pixel, mask_bit, frame_start, padding, output ready);
endinterface

interface cfarb_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] average;
  logic        centre_mask;
  logic        row_end;

  modport source (output valid, average, centre_mask, row_end, input ready);
  modport sink   (input valid, average, centre_mask, row_end, output ready);
endinterface
`default_nettype wire

FILE: src/cfar_ring_background_average_unit.sv
// ----------------------------------------------------------------------------
// cfar_ring_background_average_unit
// Ring background mean around each centre pixel, guard square left out.
// A pixel word is taken only in the idle state. One that yields a result
// walks the window through the single line store read port, then, with the
// centre mask set, runs the 16-step divider; with it clear the divider is
// skipped and the average is zero. A held result stalls the next pixel word
// as well. Reset clears control state and restores the default configuration;
// the line store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
module cfar_ring_background_average_unit
  import cfarb_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     wr_en,
  input  wire logic [CfgIndexWidth-1:0] wr_index,
  input  wire logic [CfgDataWidth-1:0]  wr_data,
  cfarb_pixel_if.sink                   pixels,
  cfarb_result_if.source                results
);

  localparam int Ring = 2 * MAX_HALF + 2;
  localparam int SW   = $clog2(Ring);
  localparam int RSW  = $clog2(Ring + 1);
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int CPW  = $clog2(MAX_WIDTH + 1);
  localparam int SCW  = CPW + 2;
  localparam int AW   = SW + CW;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CEN  = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_LAST = 3'd3;
  localparam logic [2:0] S_CNT  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [10:0] image_width;
  logic [2:0]  background_half;
  logic [2:0]  guard_half;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width     <= IMAGE_WIDTH_RESET;
      background_half <= BACKGROUND_HALF_RESET;
      guard_half      <= GUARD_HALF_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_IMAGE_WIDTH:     image_width     <= wr_data;
        CFG_BACKGROUND_HALF: background_half <= wr_data[2:0];
        CFG_GUARD_HALF:      guard_half      <= wr_data[2:0];
        default: ;
      endcase
    end
  end

  // effective settings
  logic [CPW-1:0] w;
  logic [2:0]     b;
  logic [2:0]     g;

  always_comb begin
    if (image_width == 11'd0) begin
      w = CPW'(1);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      w = CPW'(MAX_WIDTH);
    end else begin
      w = CPW'(image_width);
    end
    if (background_half == 3'd0) begin
      b = 3'd1;
    end else if (32'(background_half) > 32'(MAX_HALF)) begin
      b = 3'(MAX_HALF);
    end else begin
      b = background_half;
    end
    g = (guard_half >= b) ? b - 3'd1 : guard_half;
  end

  logic [2:0]      state;
  logic [CPW-1:0]  column_position;
  logic [RSW-1:0]  rows_seen;
  logic [SW-1:0]   ring_slot;

  logic [3:0]            rb;
  logic signed [SCW-1:0] cc;
  logic                  row_end_q;
  logic [3:0]            iy;
  logic [3:0]            ix;
  logic                  take_q;
  logic                  cen_q;
  logic                  mask_q;
  logic [SumWidth-1:0]   sum;
  logic [CountWidth-1:0] count;

  logic accept;
  assign pixels.ready = (state == S_IDLE);
  assign accept = pixels.valid && pixels.ready;

  // accept-time position update
  logic [CPW-1:0]        cp0;
  logic [RSW-1:0]        rs0;
  logic [RSW-1:0]        rs1;
  logic [SW-1:0]         slot1;
  logic [3:0]            rb_n;
  logic signed [SCW-1:0] cc_n;
  logic                  row_end_n;
  logic                  has_result;

  always_comb begin
    cp0 = pixels.frame_start ? '0 : column_position;
    rs0 = pixels.frame_start ? '0 : rows_seen;
    if (cp0 >= w) begin
      cp0 = '0;
    end
    slot1 = ring_slot;
    rs1   = rs0;
    if (cp0 == '0) begin
      slot1 = (ring_slot == SW'(Ring - 1)) ? '0 : ring_slot + SW'(1);
      if (32'(rs0) < 32'(Ring)) begin
        rs1 = rs0 + RSW'(1);
      end
    end
    if (cp0 >= CPW'(b)) begin
      rb_n       = {1'b0, b};
      cc_n       = $signed(SCW'(cp0)) - $signed(SCW'(b));
      row_end_n  = 1'b0;
      has_result = 1'b1;
    end else begin
      rb_n       = {1'b0, b} + 4'd1;
      cc_n       = $signed(SCW'(w)) - $signed(SCW'(b)) + $signed(SCW'(cp0));
      row_end_n  = (cp0 == CPW'(b - 3'd1));
      has_result = (cc_n >= 0);
    end
    if (32'(rb_n) >= 32'(rs1)) begin
      has_result = 1'b0;
    end
  end

  // window read address
  logic [4:0]            back;
  logic signed [SCW-1:0] col;
  logic [SW:0]           bk;
  logic [SW:0]           rsx;
  logic [SW-1:0]         rd_slot;
  logic                  cell_ok;
  logic                  in_guard;
  logic                  last_cell;

  always_comb begin
    if (state == S_CEN) begin
      back = {1'b0, rb};
      col  = cc;
    end else begin
      back = 5'(rb) + 5'(b) - 5'(iy);
      col  = cc + $signed(SCW'(ix)) - $signed(SCW'(b));
    end
    bk  = (SW + 1)'(back);
    rsx = {1'b0, ring_slot};
    rd_slot = (rsx >= bk) ? SW'(rsx - bk) : SW'(rsx + (SW + 1)'(Ring) - bk);
    cell_ok = (32'(back) < 32'(rows_seen)) && (col >= 0) && (col < $signed(SCW'(w)));
    in_guard = (iy >= 4'(b - g)) && (iy <= 4'(b) + 4'(g))
            && (ix >= 4'(b - g)) && (ix <= 4'(b) + 4'(g));
    last_cell = (iy == {b, 1'b0}) && (ix == {b, 1'b0});
  end

  logic [WordWidth-1:0] rdata;

  cfarb_line_store #(
    .Depth(Ring << CW),
    .AddrWidth(AW)
  ) u_store (
    .clk(clk),
    .we(accept),
    .waddr({slot1, cp0[CW-1:0]}),
    .wdata(pixels.padding ? '0 : {pixels.mask_bit, pixels.pixel}),
    .re(state == S_CEN || state == S_SUM),
    .raddr({rd_slot, col[CW-1:0]}),
    .rdata(rdata)
  );

  logic                div_start;
  logic                div_done;
  logic [AvgWidth-1:0] quotient;

  assign div_start = (state == S_CNT) && mask_q;

  cfarb_divider u_div (
    .clk(clk),
    .rst(rst),
    .start(div_start),
    .sum(sum),
    .count(count),
    .done(div_done),
    .quotient(quotient)
  );

  logic                res_valid;
  logic [AvgWidth-1:0] res_avg;
  logic                res_mask;
  logic                res_end;
  logic                out_free;

  assign results.valid       = res_valid;
  assign results.average     = res_avg;
  assign results.centre_mask = res_mask;
  assign results.row_end     = res_end;
  assign out_free = !res_valid || results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      column_position <= '0;
      rows_seen       <= '0;
      ring_slot       <= '0;
      take_q          <= 1'b0;
      cen_q           <= 1'b0;
      res_valid       <= 1'b0;
    end else begin
      take_q <= (state == S_SUM) && cell_ok && !in_guard;
      cen_q  <= (state == S_CEN);
      if (state == S_OUT && out_free) begin
        res_valid <= 1'b1;
      end else if (results.ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            column_position <= cp0 + CPW'(1);
            rows_seen       <= rs1;
            ring_slot       <= slot1;
            if (has_result) begin
              state <= S_CEN;
            end
          end
        end
        S_CEN: state <= S_SUM;
        S_SUM: begin
          if (last_cell) begin
            state <= S_LAST;
          end
        end
        S_LAST: state <= S_CNT;
        S_CNT:  state <= mask_q ? S_DIV : S_OUT;
        S_DIV: begin
          if (div_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rb        <= rb_n;
      cc        <= cc_n;
      row_end_q <= row_end_n;
      sum       <= '0;
      iy        <= '0;
      ix        <= '0;
    end else begin
      if (take_q) begin
        sum <= sum + SumWidth'(rdata[PixelWidth-1:0]);
      end
      if (state == S_SUM) begin
        if (ix == {b, 1'b0}) begin
          ix <= '0;
          iy <= iy + 4'd1;
        end else begin
          ix <= ix + 4'd1;
        end
      end
    end
    if (cen_q) begin
      mask_q <= rdata[WordWidth-1];
    end
    if (state == S_LAST) begin
      count <= CountWidth'(({1'b0, b, 1'b1} * {1'b0, b, 1'b1})
                         - ({1'b0, g, 1'b1} * {1'b0, g, 1'b1}));
    end
    if (state == S_OUT && out_free) begin
      res_avg  <= mask_q ? quotient : '0;
      res_mask <= mask_q;
      res_end  <= row_end_q;
    end
  end

  a_div_to_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && div_done) |=> (state == S_OUT))
    else $error("divider finish did not reach output stage");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && pixels.frame_start) |=> (rows_seen == RSW'(1) && column_position == CPW'(1)))
    else $error("frame start did not restart position");

  a_masked_zero: assert property (@(posedge clk) disable iff (rst)
    (results.valid && !results.centre_mask) |-> (results.average == '0))
    else $error("masked centre gave non-zero average");

  a_column_bound: assert property (@(posedge clk) disable iff (rst)
    32'(column_position) <= 32'(MAX_WIDTH))
    else $error("column position past maximum width");

endmodule
`default_nettype wire

FILE: src/cfarb_line_store.sv
// ----------------------------------------------------------------------------
// cfarb_line_store
// Ring of image rows, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module cfarb_line_store
  import cfarb_pkg::*;
#(
  parameter int Depth = 16384,
  parameter int AddrWidth = 14
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [AddrWidth-1:0] waddr,
  input  wire logic [WordWidth-1:0] wdata,
  input  wire logic                 re,
  input  wire logic [AddrWidth-1:0] raddr,
  output      logic [WordWidth-1:0] rdata
);

  logic [WordWidth-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: src/cfarb_divider.sv
// ----------------------------------------------------------------------------
// cfarb_divider
// Radix-2 restoring divider: floor(sum * 256 / count), one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module cfarb_divider
  import cfarb_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [SumWidth-1:0]   sum,
  input  wire logic [CountWidth-1:0] count,
  output      logic                  done,
  output      logic [AvgWidth-1:0]   quotient
);

  // sum < 256 * count, so the upper quotient bits are zero and the
  // remainder starts from sum[15:8]
  logic                  busy;
  logic [4:0]            step;
  logic [CountWidth-1:0] rem;
  logic [AvgWidth-1:0]   acc;
  logic [CountWidth-1:0] divisor;
  logic [CountWidth:0]   trial;
  logic                  qbit;

  assign trial = {rem, acc[AvgWidth-1]};
  assign qbit  = trial >= {1'b0, divisor};
  assign quotient = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 5'd1;
        if (step == 5'(AvgWidth - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= sum[15:8];
      acc     <= {sum[7:0], 8'd0};
      divisor <= count;
    end else if (busy) begin
      rem <= qbit ? CountWidth'(trial - {1'b0, divisor}) : trial[CountWidth-1:0];
      acc <= {acc[AvgWidth-2:0], qbit};
    end
  end

endmodule
`default_nettype wire
